// File: sv/codebook_background_subtractor_core_macros.svh
// Assertion macros for the codebook background subtractor core.
`ifndef CODEBOOK_BACKGROUND_SUBTRACTOR_CORE_MACROS_SVH
`define CODEBOOK_BACKGROUND_SUBTRACTOR_CORE_MACROS_SVH
`ifndef SYNTH
`define CBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/cbs_pkg.sv
package cbs_pkg;
	localparam int PixelCount = 524288;
	localparam int PixW = $clog2(PixelCount);
	localparam int WordsPerPixel = 8;
	localparam int SlotW = $clog2(WordsPerPixel);
	localparam int CntW = 4;
	localparam int ChanCount = 3;
	localparam int WordAddrW = PixW + SlotW;

	localparam logic [1:0] REQ_LEARN = 2'd0;
	localparam logic [1:0] REQ_CLASSIFY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	localparam logic [1:0] CFG_LEARN_BOUND = 2'd0;
	localparam logic [1:0] CFG_LOW_MARGIN = 2'd1;
	localparam logic [1:0] CFG_HIGH_MARGIN = 2'd2;
	localparam logic [1:0] CFG_STALE_SHIFT = 2'd3;

	typedef logic [7:0] chan_t [ChanCount];

	typedef struct packed {
		logic [ChanCount-1:0][7:0] lo;
		logic [ChanCount-1:0][7:0] hi;
		logic [ChanCount-1:0][7:0] smin;
		logic [ChanCount-1:0][7:0] smax;
		logic [15:0] last_hit;
		logic [15:0] stale;
	} word_t;

	typedef struct packed {
		logic [7:0] learn_bound;
		logic [7:0] low_margin;
		logic [7:0] high_margin;
		logic [2:0] stale_shift;
	} cfg_t;
endpackage

// File: sv/codebook_background_subtractor_core.sv
// Channel   | Signals                                              | Direction
// config    | cfg_we, cfg_index, cfg_data                          | in
// request   | start/busy, req_type, pixel_index, luma, chroma_*    | in
// result    | done strobe, foreground ... removed_total            | out
// From the accepting edge a request reads the pixel header (ST_PRD, ST_PHDR), then scans the
// codewords (ST_SRD and ST_SCHK each; ST_SCHK alone when the codebook is empty), runs each codeword
// through the learn update (ST_URD, ST_UWAIT, ST_UWR) or the clear pass (ST_CRD, ST_CWAIT, ST_CWR),
// adds ST_APPEND when learn appends, and finishes in ST_DONE; done is high in the cycle after that.
// A learn that misses a full codebook is among the longest cases. After reset the pixel store is
// swept clean with busy held high. Results are shown for one cycle with done; the receiver cannot stall.
`include "codebook_background_subtractor_core_macros.svh"
module codebook_background_subtractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [18:0] pixel_index,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_red,
	input  logic [7:0]  chroma_blue,
	output logic        done,
	output logic        foreground,
	output logic        matched,
	output logic        created,
	output logic        table_full,
	output logic [3:0]  entry_total,
	output logic [3:0]  removed_total
);
	localparam int SW = cbs_pkg::SlotW;
	localparam int CW = cbs_pkg::CntW;
	localparam int NC = cbs_pkg::ChanCount;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRD, ST_PHDR, ST_SRD, ST_SCHK, ST_APPEND,
		ST_URD, ST_UWAIT, ST_UWR, ST_CRD, ST_CWAIT, ST_CWR, ST_DONE
	} state_t;

	state_t state_q;
	cbs_pkg::cfg_t cfg_q;
	logic [1:0] req_q;
	logic [cbs_pkg::PixW-1:0] px_q;
	logic [NC-1:0][7:0] pix_q;
	logic [15:0] t_q;
	logic [CW-1:0] cnt_q, k_q, hit_q, kept_q;
	logic hit_v_q;
	logic [NC-1:0][7:0] lo_q, hi_q;
	logic [15:0] limit_q;

	logic w_we, p_we, clearing;
	logic [cbs_pkg::WordAddrW-1:0] w_waddr, w_raddr;
	cbs_pkg::word_t w_wdata, w_rdata;
	logic [15:0] p_rtime, p_wtime;
	logic [CW-1:0] p_rcnt, p_wcnt;

	cbs_word_ram u_words (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	cbs_pixel_ram u_pix (
		.clk(clk), .arst_n(arst_n), .we(p_we), .addr(px_q),
		.wtime(p_wtime), .wcnt(p_wcnt), .rtime(p_rtime), .rcnt(p_rcnt),
		.clearing(clearing)
	);

	assign busy = (state_q != ST_IDLE) || clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{learn_bound: 8'd10, low_margin: 8'd20, high_margin: 8'd20,
				stale_shift: 3'd1};
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbs_pkg::CFG_LEARN_BOUND: cfg_q.learn_bound <= cfg_data;
				cbs_pkg::CFG_LOW_MARGIN: cfg_q.low_margin <= cfg_data;
				cbs_pkg::CFG_HIGH_MARGIN: cfg_q.high_margin <= cfg_data;
				cbs_pkg::CFG_STALE_SHIFT: cfg_q.stale_shift <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Per-channel checks on the word just read.
	logic in_box, in_seen;
	logic [9:0] slo, shi;
	always_comb begin
		in_box = 1'b1;
		in_seen = 1'b1;
		for (int c = 0; c < NC; c++) begin
			slo = {2'b0, w_rdata.smin[c]} - {2'b0, cfg_q.low_margin};
			shi = {2'b0, w_rdata.smax[c]} + {2'b0, cfg_q.high_margin};
			if (!(w_rdata.lo[c] <= pix_q[c] && pix_q[c] <= w_rdata.hi[c])) in_box = 1'b0;
			if (!(($signed(slo) <= $signed({2'b0, pix_q[c]}))
				&& ({2'b0, pix_q[c]} <= shi))) in_seen = 1'b0;
		end
	end

	logic [15:0] t_next;
	logic [8:0] hsum;
	logic [CW-1:0] cnt_sat;
	logic [NC-1:0][7:0] lo_new, hi_new;
	always_comb begin
		cnt_sat = (p_rcnt > CW'(cbs_pkg::WordsPerPixel)) ?
			CW'(cbs_pkg::WordsPerPixel) : p_rcnt;
		t_next = (cnt_sat == '0) ? 16'd0 : p_rtime;
		if (t_next != 16'hFFFF) t_next = t_next + 16'd1;
		hsum = '0;
		for (int c = 0; c < NC; c++) begin
			hsum = {1'b0, pix_q[c]} + {1'b0, cfg_q.learn_bound};
			hi_new[c] = hsum[8] ? 8'hFF : hsum[7:0];
			lo_new[c] = (pix_q[c] > cfg_q.learn_bound) ?
				pix_q[c] - cfg_q.learn_bound : 8'd0;
		end
	end

	// Word update for the learn write-back pass.
	cbs_pkg::word_t upd;
	logic [15:0] run;
	always_comb begin
		upd = w_rdata;
		if (hit_v_q && k_q == hit_q) begin
			upd.last_hit = t_q;
			for (int c = 0; c < NC; c++) begin
				if (w_rdata.smax[c] < pix_q[c]) upd.smax[c] = pix_q[c];
				else if (w_rdata.smin[c] > pix_q[c]) upd.smin[c] = pix_q[c];
				if (w_rdata.hi[c] < hi_q[c]) upd.hi[c] = w_rdata.hi[c] + 8'd1;
				if (w_rdata.lo[c] > lo_q[c]) upd.lo[c] = w_rdata.lo[c] - 8'd1;
			end
		end
		run = (t_q >= upd.last_hit) ? t_q - upd.last_hit : 16'd0;
		if (upd.stale < run) upd.stale = run;
	end

	logic [15:0] tshift;
	assign tshift = p_rtime >> cfg_q.stale_shift;

	always_comb begin
		w_raddr = {px_q, k_q[SW-1:0]};
		w_we = 1'b0;
		w_waddr = {px_q, k_q[SW-1:0]};
		w_wdata = upd;
		p_we = 1'b0;
		p_wtime = t_q;
		p_wcnt = cnt_q;
		unique case (state_q)
			ST_APPEND: begin
				w_we = 1'b1;
				w_waddr = {px_q, cnt_q[SW-1:0]};
				for (int c = 0; c < NC; c++) begin
					w_wdata.lo[c] = lo_q[c];
					w_wdata.hi[c] = hi_q[c];
					w_wdata.smin[c] = pix_q[c];
					w_wdata.smax[c] = pix_q[c];
				end
				w_wdata.last_hit = t_q;
				w_wdata.stale = '0;
			end
			ST_UWR: w_we = 1'b1;
			ST_CWR: begin
				w_we = w_rdata.stale <= limit_q;
				w_waddr = {px_q, kept_q[SW-1:0]};
				w_wdata = w_rdata;
				w_wdata.stale = '0;
				w_wdata.last_hit = '0;
			end
			ST_DONE: begin
				p_we = (req_q == cbs_pkg::REQ_LEARN) || (req_q == cbs_pkg::REQ_CLEAR);
				p_wtime = (req_q == cbs_pkg::REQ_CLEAR) ? 16'd0 : t_q;
				p_wcnt = (req_q == cbs_pkg::REQ_CLEAR) ? kept_q : cnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			foreground <= 1'b0;
			matched <= 1'b0;
			created <= 1'b0;
			table_full <= 1'b0;
			entry_total <= '0;
			removed_total <= '0;
			hit_v_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && !clearing) begin
						req_q <= req_type;
						px_q <= pixel_index[cbs_pkg::PixW-1:0];
						pix_q <= {chroma_blue, chroma_red, luma};
						state_q <= ST_PRD;
					end
				end
				ST_PRD: state_q <= ST_PHDR;
				ST_PHDR: begin
					cnt_q <= cnt_sat;
					k_q <= '0;
					kept_q <= '0;
					hit_v_q <= 1'b0;
					foreground <= 1'b0;
					matched <= 1'b0;
					created <= 1'b0;
					table_full <= 1'b0;
					removed_total <= '0;
					t_q <= (req_q == cbs_pkg::REQ_LEARN) ? t_next : p_rtime;
					limit_q <= tshift;
					hi_q <= hi_new;
					lo_q <= lo_new;
					unique case (req_q)
						cbs_pkg::REQ_LEARN, cbs_pkg::REQ_CLASSIFY:
							state_q <= (cnt_sat == '0) ? ST_SCHK : ST_SRD;
						cbs_pkg::REQ_CLEAR:
							state_q <= (cnt_sat == '0) ? ST_DONE : ST_CRD;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_SRD: state_q <= ST_SCHK;
				ST_SCHK: begin
					// Entered with k_q == cnt_q only when the codebook is empty.
					if (k_q != cnt_q && ((req_q == cbs_pkg::REQ_LEARN) ? in_box : in_seen)) begin
						hit_v_q <= 1'b1;
						hit_q <= k_q;
						if (req_q == cbs_pkg::REQ_LEARN) begin
							matched <= 1'b1;
							k_q <= '0;
							state_q <= ST_URD;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (k_q != cnt_q && k_q + 1'b1 != cnt_q) begin
						k_q <= k_q + 1'b1;
						state_q <= ST_SRD;
					end else if (req_q == cbs_pkg::REQ_CLASSIFY) begin
						foreground <= 1'b1;
						state_q <= ST_DONE;
					end else if (cnt_q < CW'(cbs_pkg::WordsPerPixel)) begin
						created <= 1'b1;
						state_q <= ST_APPEND;
					end else begin
						table_full <= 1'b1;
						k_q <= '0;
						state_q <= ST_URD;
					end
				end
				ST_APPEND: begin
					cnt_q <= cnt_q + 1'b1;
					k_q <= '0;
					state_q <= ST_URD;
				end
				ST_URD: state_q <= ST_UWAIT;
				ST_UWAIT: state_q <= ST_UWR;
				ST_UWR: begin
					if (k_q + 1'b1 == cnt_q) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_URD;
					end
				end
				ST_CRD: state_q <= ST_CWAIT;
				ST_CWAIT: state_q <= ST_CWR;
				ST_CWR: begin
					if (w_rdata.stale <= limit_q) kept_q <= kept_q + 1'b1;
					if (k_q + 1'b1 == cnt_q) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_CRD;
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					entry_total <= (req_q == cbs_pkg::REQ_CLEAR) ? kept_q : cnt_q;
					removed_total <= (req_q == cbs_pkg::REQ_CLEAR) ? cnt_q - kept_q : '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CBS_ASSERT_NXT(a_start_leaves_idle, clk, arst_n, start && !busy, busy, "accepted word did not raise busy")
	`CBS_ASSERT_IMP(a_done_flags_onehot, clk, arst_n, done, $onehot0({matched, created, table_full}), "learn outcome flags not exclusive")
	`CBS_ASSERT_IMP(a_done_count_range, clk, arst_n, done, entry_total <= 4'd8 && removed_total <= 4'd8, "count out of range")
	`CBS_ASSERT_NXT(a_done_single, clk, arst_n, done, !done, "done held for two cycles")
endmodule

// File: sv/cbs_word_ram.sv
module cbs_word_ram (
	input  logic                              clk,
	input  logic                              we,
	input  logic [cbs_pkg::WordAddrW-1:0]     waddr,
	input  cbs_pkg::word_t                    wdata,
	input  logic [cbs_pkg::WordAddrW-1:0]     raddr,
	output cbs_pkg::word_t                    rdata
);
	cbs_pkg::word_t mem [cbs_pkg::PixelCount*cbs_pkg::WordsPerPixel];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/cbs_pixel_ram.sv
module cbs_pixel_ram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [cbs_pkg::PixW-1:0]     addr,
	input  logic [15:0]                  wtime,
	input  logic [cbs_pkg::CntW-1:0]     wcnt,
	output logic [15:0]                  rtime,
	output logic [cbs_pkg::CntW-1:0]     rcnt,
	output logic                         clearing
);
	logic [15:0] time_mem [cbs_pkg::PixelCount];
	logic [cbs_pkg::CntW-1:0] cnt_mem [cbs_pkg::PixelCount];
	logic [cbs_pkg::PixW:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (!sweep_q[cbs_pkg::PixW]) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	assign clearing = !sweep_q[cbs_pkg::PixW];

	always_ff @(posedge clk) begin
		if (clearing) begin
			time_mem[sweep_q[cbs_pkg::PixW-1:0]] <= '0;
			cnt_mem[sweep_q[cbs_pkg::PixW-1:0]] <= '0;
		end else if (we) begin
			time_mem[addr] <= wtime;
			cnt_mem[addr] <= wcnt;
		end
		rtime <= time_mem[addr];
		rcnt <= cnt_mem[addr];
	end
endmodule

// File: tb/codebook_background_subtractor_core_tb.sv
`timescale 1ns / 1ps
module codebook_background_subtractor_core_tb;

	typedef struct {
		int lo[3];
		int hi[3];
		int mn[3];
		int mx[3];
		int last;
		int stale;
	} codeword_t;

	typedef struct {
		bit       fg;
		bit       mt;
		bit       cr;
		bit       full;
		bit [3:0] ent;
		bit [3:0] rem;
	} outcome_t;

	class codebook_scoreboard;
		int learn_bound = 10;
		int low_margin = 20;
		int high_margin = 20;
		int stale_shift = 1;
		int ptime[int];
		int wcount[int];
		codeword_t words[int];
		outcome_t pending[$];
		int errors = 0;

		function int count_of(int px);
			return wcount.exists(px) ? wcount[px] : 0;
		endfunction

		function void set_reg(logic [1:0] idx, int val);
			case (idx)
				cbs_pkg::CFG_LEARN_BOUND: learn_bound = val & 255;
				cbs_pkg::CFG_LOW_MARGIN: low_margin = val & 255;
				cbs_pkg::CFG_HIGH_MARGIN: high_margin = val & 255;
				cbs_pkg::CFG_STALE_SHIFT: stale_shift = val & 7;
			endcase
		endfunction

		function outcome_t predict(logic [1:0] req, int px, int pix[3]);
			outcome_t r;
			int cnt, t, hit, k, c, ok, kept, limit, run;
			int hb[3];
			int lb[3];
			codeword_t w;
			r = '{default: 0};
			cnt = count_of(px);
			case (req)
				cbs_pkg::REQ_LEARN: begin
					t = (cnt == 0) ? 0 : ptime[px];
					if (t < 65535) t++;
					ptime[px] = t;
					for (c = 0; c < 3; c++) begin
						hb[c] = (pix[c] + learn_bound > 255) ? 255 : pix[c] + learn_bound;
						lb[c] = (pix[c] > learn_bound) ? pix[c] - learn_bound : 0;
					end
					hit = cnt;
					for (k = 0; k < cnt && hit == cnt; k++) begin
						w = words[px * 8 + k];
						ok = 1;
						for (c = 0; c < 3; c++)
							if (!(w.lo[c] <= pix[c] && pix[c] <= w.hi[c])) ok = 0;
						if (ok) hit = k;
					end
					if (hit < cnt) begin
						w = words[px * 8 + hit];
						w.last = t;
						for (c = 0; c < 3; c++) begin
							if (w.mx[c] < pix[c]) w.mx[c] = pix[c];
							else if (w.mn[c] > pix[c]) w.mn[c] = pix[c];
						end
						words[px * 8 + hit] = w;
						r.mt = 1;
					end else if (cnt < cbs_pkg::WordsPerPixel) begin
						for (c = 0; c < 3; c++) begin
							w.lo[c] = lb[c];
							w.hi[c] = hb[c];
							w.mn[c] = pix[c];
							w.mx[c] = pix[c];
						end
						w.last = t;
						w.stale = 0;
						words[px * 8 + cnt] = w;
						cnt++;
						wcount[px] = cnt;
						r.cr = 1;
					end else begin
						r.full = 1;
					end
					for (k = 0; k < cnt; k++) begin
						w = words[px * 8 + k];
						run = (t >= w.last) ? t - w.last : 0;
						if (w.stale < run) w.stale = run;
						words[px * 8 + k] = w;
					end
					if (r.mt) begin
						w = words[px * 8 + hit];
						for (c = 0; c < 3; c++) begin
							if (w.hi[c] < hb[c]) w.hi[c]++;
							if (w.lo[c] > lb[c]) w.lo[c]--;
						end
						words[px * 8 + hit] = w;
					end
					r.ent = 4'(cnt);
				end
				cbs_pkg::REQ_CLASSIFY: begin
					ok = 0;
					for (k = 0; k < cnt && !ok; k++) begin
						w = words[px * 8 + k];
						ok = 1;
						for (c = 0; c < 3; c++)
							if (!(w.mn[c] - low_margin <= pix[c] &&
									pix[c] <= w.mx[c] + high_margin)) ok = 0;
					end
					r.fg = !ok;
					r.ent = 4'(cnt);
				end
				cbs_pkg::REQ_CLEAR: begin
					limit = (ptime.exists(px) ? ptime[px] : 0) >> stale_shift;
					kept = 0;
					for (k = 0; k < cnt; k++) begin
						w = words[px * 8 + k];
						if (w.stale > limit) continue;
						w.stale = 0;
						w.last = 0;
						words[px * 8 + kept] = w;
						kept++;
					end
					ptime[px] = 0;
					wcount[px] = kept;
					r.ent = 4'(kept);
					r.rem = 4'(cnt - kept);
				end
				default: r.ent = 4'(cnt);
			endcase
			return r;
		endfunction

		function void note(logic [1:0] req, int px, int y, int cr, int cb);
			int pix[3];
			pix = '{y, cr, cb};
			pending = {pending, predict(req, px, pix)};
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check(outcome_t got);
			outcome_t e;
			if (pending.size() == 0) begin
				$display("unexpected result word at %0t", $realtime);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.fg != e.fg) report_mismatch("foreground", got.fg, e.fg);
			if (got.mt != e.mt) report_mismatch("matched", got.mt, e.mt);
			if (got.cr != e.cr) report_mismatch("created", got.cr, e.cr);
			if (got.full != e.full) report_mismatch("table_full", got.full, e.full);
			if (got.ent != e.ent) report_mismatch("entry_total", got.ent, e.ent);
			if (got.rem != e.rem) report_mismatch("removed_total", got.rem, e.rem);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic start = 0;
	logic busy;
	logic [1:0] req_type = '0;
	logic [18:0] pixel_index = '0;
	logic [7:0] luma = '0;
	logic [7:0] chroma_red = '0;
	logic [7:0] chroma_blue = '0;
	logic done;
	logic foreground, matched, created, table_full;
	logic [3:0] entry_total, removed_total;

	codebook_scoreboard sb = new();
	int gap_pct = 0;
	int pool[8];
	int tint[8][3];

	codebook_background_subtractor_core i_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && done) begin
			got.fg = foreground;
			got.mt = matched;
			got.cr = created;
			got.full = table_full;
			got.ent = entry_total;
			got.rem = removed_total;
			sb.check(got);
		end
	end

	initial begin
		#36_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task send_word(logic [1:0] req, int px, int y, int cr, int cb);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct)
			repeat ($urandom_range(1, 20)) @(negedge clk);
		req_type = req;
		pixel_index = 19'(px);
		luma = 8'(y);
		chroma_red = 8'(cr);
		chroma_blue = 8'(cb);
		start = 1;
		while (busy) @(negedge clk);
		@(posedge clk);
		sb.note(req, px, y, cr, cb);
		@(negedge clk);
		start = 0;
	endtask

	task drain;
		int guard;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (30) @(negedge clk);
	endtask

	task write_regs(int lb, int lm, int hm, int sh);
		int v[4];
		v = '{lb, lm, hm, sh};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we = 1;
			cfg_index = 2'(i);
			cfg_data = 8'(v[i]);
			sb.set_reg(2'(i), v[i]);
			@(negedge clk);
		end
		cfg_we = 0;
	endtask

	function int jitter(int b);
		int v;
		v = b + int'($urandom_range(0, 24)) - 12;
		return (v < 0) ? 0 : (v > 255) ? 255 : v;
	endfunction

	initial begin
		int p, r, n;
		logic [1:0] rq;
		pool = '{0, 524287, 'h2AAAA, 'h55555, 0, 0, 0, 0};
		for (int i = 4; i < 8; i++) pool[i] = $urandom_range(1, 524286);
		for (int i = 0; i < 8; i++)
			for (int c = 0; c < 3; c++) tint[i][c] = $urandom_range(255);
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		while (busy) @(negedge clk);
		write_regs(10, 20, 20, 1);

		send_word(cbs_pkg::REQ_CLASSIFY, 0, 100, 100, 100);
		send_word(cbs_pkg::REQ_LEARN, 0, 0, 0, 0);
		send_word(cbs_pkg::REQ_LEARN, 0, 255, 255, 255);
		send_word(cbs_pkg::REQ_LEARN, 0, 5, 3, 8);
		send_word(cbs_pkg::REQ_LEARN, 0, 250, 255, 246);
		send_word(cbs_pkg::REQ_CLASSIFY, 0, 20, 0, 25);
		send_word(cbs_pkg::REQ_CLASSIFY, 0, 128, 128, 128);
		send_word(cbs_pkg::REQ_RESERVED, 0, 1, 2, 3);
		for (int i = 0; i < 8; i++)
			send_word(cbs_pkg::REQ_LEARN, 524287, i * 30, 255 - i * 30, i * 17);
		send_word(cbs_pkg::REQ_LEARN, 524287, 15, 240, 250);
		send_word(cbs_pkg::REQ_LEARN, 524287, 0, 255, 0);
		send_word(cbs_pkg::REQ_CLEAR, 524287, 0, 0, 0);
		send_word(cbs_pkg::REQ_CLEAR, 0, 255, 255, 255);
		send_word(cbs_pkg::REQ_CLASSIFY, 524287, 0, 255, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_regs(0, 0, 0, 0);
				1: write_regs(255, 255, 255, 7);
				2: write_regs($urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(7));
				default: write_regs(10, 20, 20, 1);
			endcase
			for (int i = 0; i < 470; i++) begin
				n = ph * 470 + i;
				gap_pct = (n < 630) ? 26 : (n < 1260) ? 62 : 0;
				if (n == 1000) drain();
				p = $urandom_range(7);
				r = $urandom_range(99);
				rq = (r < 60) ? cbs_pkg::REQ_LEARN : (r < 85) ? cbs_pkg::REQ_CLASSIFY :
					(r < 95) ? cbs_pkg::REQ_CLEAR : cbs_pkg::REQ_RESERVED;
				if ($urandom_range(99) < 80)
					send_word(rq, pool[p], jitter(tint[p][0]), jitter(tint[p][1]),
						jitter(tint[p][2]));
				else
					send_word(rq, (r & 1) ? $urandom_range(524287) : pool[p],
						$urandom_range(255), $urandom_range(255), $urandom_range(255));
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
